// File: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands, clocked on clock, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property
`define PGM_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// overlapping implication
`define PGM_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`endif

// File: sv/pgm_pkg.sv
// ----------------------------------------------------------------------------
// pgm_pkg
// Shared widths and types of the pairwise gcd matrix block.
// ----------------------------------------------------------------------------
package pgm_pkg;

   localparam int SIZE_W  = 32;
   localparam int IDX_W   = 3;
   localparam int CNT_W   = 4;
   localparam int TALLY_W = 5;
   localparam int SHIFT_W = 5;

   typedef struct packed {
      logic              done;
      logic [SIZE_W-1:0] value;
   } gcd_rsp_type;

endpackage

// File: sv/pgm_chan_if.sv
// ----------------------------------------------------------------------------
// pgm_chan_if
// Valid/ready channels: size words in, matrix entry words out.
// ----------------------------------------------------------------------------
interface pgm_req_if;
   import pgm_pkg::*;

   logic              valid;
   logic              ready;
   logic [SIZE_W-1:0] dim_size;
   logic              last_size;

   modport source (output valid, dim_size, last_size, input ready);
   modport sink   (input valid, dim_size, last_size, output ready);
endinterface

interface pgm_rsp_if;
   import pgm_pkg::*;

   logic               valid;
   logic               ready;
   logic [IDX_W-1:0]   row_index;
   logic [IDX_W-1:0]   col_index;
   logic [SIZE_W-1:0]  common_divisor;
   logic               is_coprime;
   logic [TALLY_W-1:0] pair_count;
   logic               too_many;
   logic               last_entry;

   modport source (output valid, row_index, col_index, common_divisor, is_coprime,
                   pair_count, too_many, last_entry, input ready);
   modport sink   (input valid, row_index, col_index, common_divisor, is_coprime,
                   pair_count, too_many, last_entry, output ready);
endinterface

// File: sv/pgm_size_ram.sv
// ----------------------------------------------------------------------------
// pgm_size_ram
// Size store: one write port, two registered read ports.
// ----------------------------------------------------------------------------
module pgm_size_ram #(
   parameter int  DEPTH = 8,
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                      clock,
   input  logic                      wr_en,
   input  logic [AW-1:0]             wr_addr,
   input  logic [pgm_pkg::SIZE_W-1:0] wr_data,
   input  logic [AW-1:0]             rd_addr_a,
   input  logic [AW-1:0]             rd_addr_b,
   output logic [pgm_pkg::SIZE_W-1:0] rd_data_a,
   output logic [pgm_pkg::SIZE_W-1:0] rd_data_b
);
   import pgm_pkg::*;

   logic [SIZE_W-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
   end

endmodule

// File: sv/pgm_gcd_unit.sv
// ----------------------------------------------------------------------------
// pgm_gcd_unit
// Iterative binary gcd, one halving or subtract step per cycle.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pgm_gcd_unit (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [pgm_pkg::SIZE_W-1:0] opnd_a,
   input  logic [pgm_pkg::SIZE_W-1:0] opnd_b,
   output pgm_pkg::gcd_rsp_type       gcd_rsp
);
   import pgm_pkg::*;

   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [SIZE_W-1:0]  a_ff, a_in;
   logic [SIZE_W-1:0]  b_ff, b_in;
   logic [SHIFT_W-1:0] k_ff, k_in;
   logic [SIZE_W-1:0]  value_ff, value_in;

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      a_in     = a_ff;
      b_in     = b_ff;
      k_in     = k_ff;
      value_in = value_ff;
      if (start) begin
         busy_in = 1'b1;
         a_in    = opnd_a;
         b_in    = opnd_b;
         k_in    = '0;
      end else if (busy_ff) begin
         if (a_ff == '0 || b_ff == '0) begin
            busy_in  = 1'b0;
            done_in  = 1'b1;
            value_in = (a_ff | b_ff) << k_ff;
         end else if (!a_ff[0] && !b_ff[0]) begin
            a_in = a_ff >> 1;
            b_in = b_ff >> 1;
            k_in = k_ff + SHIFT_W'(1);
         end else if (!a_ff[0]) begin
            a_in = a_ff >> 1;
         end else if (!b_ff[0]) begin
            b_in = b_ff >> 1;
         end else if (a_ff >= b_ff) begin
            a_in = a_ff - b_ff;
         end else begin
            b_in = b_ff - a_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      a_ff     <= a_in;
      b_ff     <= b_in;
      k_ff     <= k_in;
      value_ff <= value_in;
   end

   assign gcd_rsp.done  = done_ff;
   assign gcd_rsp.value = value_ff;

   `PGM_ASSERT_IMP(a_done_after_busy, done_ff, $past(busy_ff) && !busy_ff, "gcd done without run")

endmodule

// File: sv/pairwise_gcd_matrix_top.sv
// Load: one size word per cycle; after the closing word each entry is read from the
//   size store, started in the binary gcd unit (or, on the diagonal, taken straight
//   from the store), computed, and held in the output word register until sent.
// Entries: N*N per set, one at a time; the next is fetched after the last is sent.
// Reset (synchronous): counters, flags and the sequencer clear; the size store
//   is not cleared and holds whatever the current set wrote.
// ----------------------------------------------------------------------------
// pairwise_gcd_matrix_top
// Loads a set of sizes into the size store, then emits the pairwise gcd matrix.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pairwise_gcd_matrix_top #(
   parameter int MAX_DIMS = 8
) (
   input  logic      clock,
   input  logic      reset,
   pgm_req_if.sink   req_ch,
   pgm_rsp_if.source rsp_ch
);
   import pgm_pkg::*;

   localparam int AW = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;

   typedef enum logic [4:0] {
      ST_LOAD  = 5'b00001,
      ST_FETCH = 5'b00010,
      ST_START = 5'b00100,
      ST_CALC  = 5'b01000,
      ST_SEND  = 5'b10000
   } state_type;

   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [CNT_W-1:0]   n_ff, n_in;
   logic               ovf_ff, ovf_in;
   logic [TALLY_W-1:0] tally_ff, tally_in;
   logic [IDX_W-1:0]   i_ff, i_in;
   logic [IDX_W-1:0]   j_ff, j_in;

   logic [IDX_W-1:0]   row_ff, col_ff;
   logic [SIZE_W-1:0]  div_ff;
   logic               cop_ff, many_ff, fin_ff;
   logic [TALLY_W-1:0] pair_ff;

   logic               req_acc, rsp_acc, room, wr_en;
   logic               diag, i_last, j_last, fin, cop, capture, gcd_start;
   logic [SIZE_W-1:0]  rd_a, rd_b, value;
   logic [TALLY_W-1:0] tally_inc;
   gcd_rsp_type        gcd_rsp;

   assign req_ch.ready = (state_ff == ST_LOAD);
   assign rsp_ch.valid = (state_ff == ST_SEND);
   assign req_acc      = req_ch.valid && req_ch.ready;
   assign rsp_acc      = rsp_ch.valid && rsp_ch.ready;
   assign room         = cnt_ff < CNT_W'(MAX_DIMS);
   assign wr_en        = req_acc && room;

   pgm_size_ram #(.DEPTH(MAX_DIMS)) u_ram (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (cnt_ff[AW-1:0]),
      .wr_data   (req_ch.dim_size),
      .rd_addr_a (i_ff[AW-1:0]),
      .rd_addr_b (j_ff[AW-1:0]),
      .rd_data_a (rd_a),
      .rd_data_b (rd_b)
   );

   assign gcd_start = (state_ff == ST_START) && !diag;

   pgm_gcd_unit u_gcd (
      .clock   (clock),
      .reset   (reset),
      .start   (gcd_start),
      .opnd_a  (rd_a),
      .opnd_b  (rd_b),
      .gcd_rsp (gcd_rsp)
   );

   always_comb begin
      diag      = (i_ff == j_ff);
      i_last    = (CNT_W'(i_ff) + CNT_W'(1)) == n_ff;
      j_last    = (CNT_W'(j_ff) + CNT_W'(1)) == n_ff;
      fin       = i_last && j_last;
      value     = diag ? rd_a : gcd_rsp.value;
      cop       = (value == SIZE_W'(1));
      tally_inc = tally_ff + TALLY_W'(cop && (i_ff < j_ff));
      capture   = ((state_ff == ST_START) && diag) ||
                  ((state_ff == ST_CALC) && gcd_rsp.done);
   end

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      n_in     = n_ff;
      ovf_in   = ovf_ff;
      tally_in = tally_ff;
      i_in     = i_ff;
      j_in     = j_ff;
      case (state_ff)
         ST_LOAD: begin
            if (req_acc) begin
               cnt_in = room ? cnt_ff + CNT_W'(1) : cnt_ff;
               ovf_in = ovf_ff | !room;
               if (req_ch.last_size) begin
                  n_in     = cnt_in;
                  i_in     = '0;
                  j_in     = '0;
                  state_in = ST_FETCH;
               end
            end
         end
         ST_FETCH: begin
            state_in = ST_START;
         end
         ST_START: begin
            state_in = diag ? ST_SEND : ST_CALC;
         end
         ST_CALC: begin
            if (gcd_rsp.done) begin
               state_in = ST_SEND;
            end
         end
         ST_SEND: begin
            if (rsp_acc) begin
               if (fin_ff) begin
                  cnt_in   = '0;
                  ovf_in   = 1'b0;
                  tally_in = '0;
                  state_in = ST_LOAD;
               end else begin
                  if (j_last) begin
                     i_in = i_ff + IDX_W'(1);
                     j_in = '0;
                  end else begin
                     j_in = j_ff + IDX_W'(1);
                  end
                  state_in = ST_FETCH;
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
      if (capture) begin
         tally_in = tally_inc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
         cnt_ff   <= '0;
         n_ff     <= '0;
         ovf_ff   <= 1'b0;
         tally_ff <= '0;
         i_ff     <= '0;
         j_ff     <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         n_ff     <= n_in;
         ovf_ff   <= ovf_in;
         tally_ff <= tally_in;
         i_ff     <= i_in;
         j_ff     <= j_in;
      end
   end

   // output word register
   always_ff @(posedge clock) begin
      if (capture) begin
         row_ff  <= i_ff;
         col_ff  <= j_ff;
         div_ff  <= value;
         cop_ff  <= cop;
         pair_ff <= fin ? tally_inc : '0;
         many_ff <= ovf_ff;
         fin_ff  <= fin;
      end
   end

   assign rsp_ch.row_index      = row_ff;
   assign rsp_ch.col_index      = col_ff;
   assign rsp_ch.common_divisor = div_ff;
   assign rsp_ch.is_coprime     = cop_ff;
   assign rsp_ch.pair_count     = pair_ff;
   assign rsp_ch.too_many       = many_ff;
   assign rsp_ch.last_entry     = fin_ff;

   `PGM_ASSERT_IMP(a_send_blocks_load, rsp_ch.valid, !req_ch.ready, "load open while sending")
   `PGM_ASSERT_IMP(a_last_on_diag, rsp_ch.valid && fin_ff, row_ff == col_ff, "last off diagonal")
   `PGM_ASSERT(a_count_bound, cnt_ff <= CNT_W'(MAX_DIMS), "size count beyond store depth")
   `PGM_ASSERT_IMP(a_gcd_start_once, gcd_start, $past(state_ff) != ST_START, "gcd started twice")

endmodule
